>>> design/mjec_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mjec_pkg - shared definitions of the joint effort controller
// sizes, field positions, codes and the accumulator control bundle
// ----------------------------------------------------------------------------
package mjec_pkg;

   // network geometry and number format
   localparam int MAX_LAYERS = 4;
   localparam int MAX_WIDTH  = 16;
   localparam int FRAC_BITS  = 16;

   // field widths
   localparam int MODE_W   = 2;
   localparam int LAYER_W  = 2;
   localparam int IDX_W    = 4;
   localparam int DATA_W   = 32;
   localparam int WIDTH_W  = 5;
   localparam int STATUS_W = 2;

   // request tdata layout, lowest bit first
   localparam int REQ_LAYER_LSB = 0;
   localparam int REQ_ROW_LSB   = REQ_LAYER_LSB + LAYER_W;
   localparam int REQ_COL_LSB   = REQ_ROW_LSB + IDX_W;
   localparam int REQ_VALUE_LSB = REQ_COL_LSB + IDX_W;
   localparam int REQ_WIDTH_LSB = REQ_VALUE_LSB + DATA_W;
   localparam int REQ_POS_LSB   = REQ_WIDTH_LSB + WIDTH_W;
   localparam int REQ_VEL_LSB   = REQ_POS_LSB + DATA_W;
   localparam int REQ_TGT_LSB   = REQ_VEL_LSB + DATA_W;
   localparam int REQ_BITS      = REQ_TGT_LSB + DATA_W;
   localparam int REQ_DATA_W    = ((REQ_BITS + 7) / 8) * 8;
   localparam int REQ_USER_W    = MODE_W;

   // response tdata layout, lowest bit first
   localparam int RSP_DRIVE_LSB  = 0;
   localparam int RSP_ERROR_LSB  = RSP_DRIVE_LSB + DATA_W;
   localparam int RSP_STATUS_LSB = RSP_ERROR_LSB + DATA_W;
   localparam int RSP_BITS       = RSP_STATUS_LSB + STATUS_W;
   localparam int RSP_DATA_W     = ((RSP_BITS + 7) / 8) * 8;

   // configuration port
   localparam int CSR_IDX_W     = 2;
   localparam int NUM_LAYERS_W  = 3;
   localparam int RELU_MASK_W   = 4;
   localparam int CSR_DATA_W    = 4;

   // memory address widths
   localparam int WADDR_W = $clog2(MAX_LAYERS * MAX_WIDTH * MAX_WIDTH);
   localparam int BADDR_W = $clog2(MAX_LAYERS * MAX_WIDTH);
   localparam int AADDR_W = $clog2(2 * MAX_WIDTH);
   localparam int LI_W    = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;

   // accumulator: bias plus MAX_WIDTH shifted products, exact
   localparam int TERM_W = 2 * DATA_W - FRAC_BITS;
   localparam int ACC_W  = TERM_W + $clog2(MAX_WIDTH) + 1;

   typedef enum logic [MODE_W-1:0] {
      MODE_WEIGHT = 2'd0,
      MODE_BIAS   = 2'd1,
      MODE_WIDTH  = 2'd2,
      MODE_EVAL   = 2'd3
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_BAD_INDEX = 2'd1,
      STATUS_SAT       = 2'd2
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_NUM_LAYERS = 2'd0,
      REG_RELU_MASK  = 2'd1
   } reg_index_type;

   // accumulator controls from the sequencer
   typedef struct packed {
      logic load_bias;
      logic mul_valid;
   } mjec_mac_ctrl_type;

endpackage

>>> design/mjec_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mjec_ram - generic simple dual port ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module mjec_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/mjec_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mjec_mac - fixed point multiply accumulate unit
// registered product, exact wide accumulator, saturated 32 bit result
// ----------------------------------------------------------------------------
module mjec_mac import mjec_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  mjec_mac_ctrl_type        ctrl,
   input  logic signed [DATA_W-1:0] bias,
   input  logic signed [DATA_W-1:0] act,
   input  logic signed [DATA_W-1:0] weight,
   output logic signed [DATA_W-1:0] result,
   output logic                     overflow
);

   localparam logic signed [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic signed [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};
   localparam logic signed [ACC_W-1:0]  SAT_HI   = ACC_W'(DATA_MAX);
   localparam logic signed [ACC_W-1:0]  SAT_LO   = ACC_W'(DATA_MIN);

   logic signed [2*DATA_W-1:0] prod_ff, prod_in;
   logic                       prod_valid_ff;
   logic signed [ACC_W-1:0]    acc_ff, acc_in;
   logic signed [TERM_W-1:0]   term;
   logic                       over_hi, over_lo;

   assign prod_in = act * weight;
   // dropping the fraction bits floors toward minus infinity
   assign term    = prod_ff[2*DATA_W-1:FRAC_BITS];

   always_comb begin
      acc_in = acc_ff;
      if (ctrl.load_bias) begin
         acc_in = ACC_W'(bias);
      end else if (prod_valid_ff) begin
         acc_in = acc_ff + ACC_W'(term);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
      end else begin
         prod_valid_ff <= ctrl.mul_valid;
      end
      if (ctrl.mul_valid) begin
         prod_ff <= prod_in;
      end
      acc_ff <= acc_in;
   end

   assign over_hi  = acc_ff > SAT_HI;
   assign over_lo  = acc_ff < SAT_LO;
   assign overflow = over_hi || over_lo;

   always_comb begin
      if (over_hi) begin
         result = DATA_MAX;
      end else if (over_lo) begin
         result = DATA_MIN;
      end else begin
         result = acc_ff[DATA_W-1:0];
      end
   end

endmodule

>>> design/mlp_joint_effort_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlp_joint_effort_controller - neural network joint effort controller
// fixed point multilayer perceptron with relu, weights held in ram
// ----------------------------------------------------------------------------
// usage
//   req channel: tuser carries the mode, tdata the table index, word, width
//   and the joint position, velocity and target. write requests load the
//   weight ram, the bias ram or a layer width; an evaluate request runs the
//   network on (position, velocity, target - position, target).
//   rsp channel: one response per request with drive, error and status.
//   csr port: num_layers and relu_mask, to be written by the user only
//   while the block idles; the block itself does not enforce it.
// request flow
//   a write request answers in the next cycle, one request per cycle while
//   rsp_tready is high and no evaluate runs. an evaluate works through each
//   output column: a bias read, one product per cycle from the single
//   multiplier and the one read port of the weight ram, a pipeline drain
//   and a store. one evaluate is in flight at a time.
// reset and stall
//   reset clears the layer widths to one, num_layers to one and relu_mask
//   to zero; weight and bias rams hold whatever was written.
//   a response waits in the output register while rsp_tready is low; in idle a
//   new request is taken as soon as that register is free or being drained.
// ----------------------------------------------------------------------------
module mlp_joint_effort_controller import mjec_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_USER_W-1:0] req_tuser,  // mode
   input  logic [REQ_DATA_W-1:0] req_tdata,  // layer, row, column, value, width,
                                             // position, velocity, target, pad
   // response channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // drive, error, status, pad
   // configuration
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BIAS,
      ST_ROWS,
      ST_DRAIN,
      ST_STORE,
      ST_FINISH
   } state_type;

   // request fields
   mode_type                  req_mode;
   logic [LAYER_W-1:0]        req_layer;
   logic [IDX_W-1:0]          req_row;
   logic [IDX_W-1:0]          req_col;
   logic signed [DATA_W-1:0]  req_value;
   logic [WIDTH_W-1:0]        req_width;
   logic signed [DATA_W-1:0]  req_pos;
   logic signed [DATA_W-1:0]  req_vel;
   logic signed [DATA_W-1:0]  req_tgt;

   assign req_mode  = mode_type'(req_tuser);
   assign req_layer = req_tdata[REQ_LAYER_LSB +: LAYER_W];
   assign req_row   = req_tdata[REQ_ROW_LSB +: IDX_W];
   assign req_col   = req_tdata[REQ_COL_LSB +: IDX_W];
   assign req_value = req_tdata[REQ_VALUE_LSB +: DATA_W];
   assign req_width = req_tdata[REQ_WIDTH_LSB +: WIDTH_W];
   assign req_pos   = req_tdata[REQ_POS_LSB +: DATA_W];
   assign req_vel   = req_tdata[REQ_VEL_LSB +: DATA_W];
   assign req_tgt   = req_tdata[REQ_TGT_LSB +: DATA_W];

   // registers
   state_type                 state_ff, state_in;
   logic [NUM_LAYERS_W-1:0]   num_layers_ff, num_layers_in;
   logic [RELU_MASK_W-1:0]    relu_mask_ff, relu_mask_in;
   logic [WIDTH_W-1:0]        lw_ff [MAX_LAYERS];
   logic [LI_W-1:0]           l_ff, l_in;
   logic [IDX_W-1:0]          r_ff, r_in;
   logic [IDX_W-1:0]          c_ff, c_in;
   logic                      cur_ff, cur_in;
   logic                      drain_ff, drain_in;
   logic                      issue_ff;
   logic                      bias_v_ff;
   logic                      l0_ff;
   logic signed [DATA_W-1:0]  x_ff, x_in;
   logic signed [DATA_W-1:0]  pos_ff, vel_ff, tgt_ff, err_ff, err_in;
   logic                      sat_ff, sat_in;
   logic signed [DATA_W-1:0]  out0_ff, out0_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0]  rsp_drive_ff, rsp_drive_in;
   logic signed [DATA_W-1:0]  rsp_error_ff, rsp_error_in;
   status_type                rsp_status_ff, rsp_status_in;

   // handshake
   logic req_take;
   logic rsp_free;

   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && rsp_free;
   assign req_take   = req_tvalid && req_tready;

   // write index checks
   logic layer_ok, row_ok, col_ok, width_ok, write_ok;

   assign layer_ok = int'(req_layer) < MAX_LAYERS;
   assign row_ok   = int'(req_row) < MAX_WIDTH;
   assign col_ok   = int'(req_col) < MAX_WIDTH;
   assign width_ok = (req_width != '0) && (int'(req_width) <= MAX_WIDTH);

   always_comb begin
      case (req_mode)
         MODE_WEIGHT: write_ok = layer_ok && row_ok && col_ok;
         MODE_BIAS:   write_ok = layer_ok && col_ok;
         MODE_WIDTH:  write_ok = layer_ok && width_ok;
         default:     write_ok = 1'b1;
      endcase
   end

   // error term with saturation
   logic signed [DATA_W:0] diff;
   logic                   diff_hi, diff_lo;

   assign diff    = {req_tgt[DATA_W-1], req_tgt} - {req_pos[DATA_W-1], req_pos};
   assign diff_hi = !diff[DATA_W] && diff[DATA_W-1];
   assign diff_lo = diff[DATA_W] && !diff[DATA_W-1];

   always_comb begin
      if (diff_hi) begin
         err_in = {1'b0, {(DATA_W-1){1'b1}}};
      end else if (diff_lo) begin
         err_in = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
         err_in = diff[DATA_W-1:0];
      end
   end

   // layer geometry for the running evaluate
   logic [NUM_LAYERS_W-1:0] nl_eff;
   logic [WIDTH_W-1:0]      dim;
   logic [WIDTH_W-1:0]      w_cur;
   logic                    last_row, last_col, last_layer;
   logic                    relu_on;

   always_comb begin
      if (num_layers_ff == '0) begin
         nl_eff = NUM_LAYERS_W'(1);
      end else if (int'(num_layers_ff) > MAX_LAYERS) begin
         nl_eff = NUM_LAYERS_W'(MAX_LAYERS);
      end else begin
         nl_eff = num_layers_ff;
      end
   end

   // layer 0 sees the four joint inputs
   assign dim        = (l_ff == '0) ? WIDTH_W'(4) : lw_ff[l_ff - LI_W'(1)];
   assign w_cur      = lw_ff[l_ff];
   assign last_row   = (WIDTH_W'(r_ff) + WIDTH_W'(1)) == dim;
   assign last_col   = (WIDTH_W'(c_ff) + WIDTH_W'(1)) == w_cur;
   assign last_layer = (NUM_LAYERS_W'(l_ff) + NUM_LAYERS_W'(1)) == nl_eff;
   assign relu_on    = relu_mask_ff[l_ff];

   // memories
   logic                     w_we;
   logic [WADDR_W-1:0]       w_waddr, w_raddr;
   logic [DATA_W-1:0]        w_rdata;
   logic                     b_we;
   logic [BADDR_W-1:0]       b_waddr, b_raddr;
   logic [DATA_W-1:0]        b_rdata;
   logic                     a_we;
   logic [AADDR_W-1:0]       a_waddr, a_raddr;
   logic [DATA_W-1:0]        a_rdata;
   logic signed [DATA_W-1:0] a_wdata;

   assign w_we    = req_take && (req_mode == MODE_WEIGHT) && write_ok;
   assign w_waddr = WADDR_W'((int'(req_layer) * MAX_WIDTH + int'(req_row)) * MAX_WIDTH
                             + int'(req_col));
   assign w_raddr = WADDR_W'((int'(l_ff) * MAX_WIDTH + int'(r_ff)) * MAX_WIDTH + int'(c_ff));

   assign b_we    = req_take && (req_mode == MODE_BIAS) && write_ok;
   assign b_waddr = BADDR_W'(int'(req_layer) * MAX_WIDTH + int'(req_col));
   assign b_raddr = BADDR_W'(int'(l_ff) * MAX_WIDTH + int'(c_ff));

   // ping-pong halves of the activation ram: read from cur, write to the other
   assign a_we    = state_ff == ST_STORE;
   assign a_waddr = AADDR_W'(int'(!cur_ff) * MAX_WIDTH + int'(c_ff));
   assign a_raddr = AADDR_W'(int'(cur_ff) * MAX_WIDTH + int'(r_ff));

   mjec_ram #(.WIDTH(DATA_W), .DEPTH(MAX_LAYERS * MAX_WIDTH * MAX_WIDTH)) u_weight_ram (
      .clock   (clock),
      .wr_en   (w_we),
      .wr_addr (w_waddr),
      .wr_data (req_value),
      .rd_addr (w_raddr),
      .rd_data (w_rdata)
   );

   mjec_ram #(.WIDTH(DATA_W), .DEPTH(MAX_LAYERS * MAX_WIDTH)) u_bias_ram (
      .clock   (clock),
      .wr_en   (b_we),
      .wr_addr (b_waddr),
      .wr_data (req_value),
      .rd_addr (b_raddr),
      .rd_data (b_rdata)
   );

   mjec_ram #(.WIDTH(DATA_W), .DEPTH(2 * MAX_WIDTH)) u_act_ram (
      .clock   (clock),
      .wr_en   (a_we),
      .wr_addr (a_waddr),
      .wr_data (a_wdata),
      .rd_addr (a_raddr),
      .rd_data (a_rdata)
   );

   // multiply accumulate
   mjec_mac_ctrl_type        mac_ctrl;
   logic signed [DATA_W-1:0] mac_act;
   logic signed [DATA_W-1:0] mac_result;
   logic                     mac_overflow;

   assign mac_ctrl.load_bias = bias_v_ff;
   assign mac_ctrl.mul_valid = issue_ff;
   // layer 0 operands come from the request registers, aligned with ram latency
   assign mac_act            = l0_ff ? x_ff : a_rdata;

   mjec_mac u_mac (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (mac_ctrl),
      .bias     (b_rdata),
      .act      (mac_act),
      .weight   (w_rdata),
      .result   (mac_result),
      .overflow (mac_overflow)
   );

   // relu on the saturated column result
   assign a_wdata = (relu_on && mac_result[DATA_W-1]) ? '0 : mac_result;

   always_comb begin
      case (r_ff[1:0])
         2'd0:    x_in = pos_ff;
         2'd1:    x_in = vel_ff;
         2'd2:    x_in = err_ff;
         default: x_in = tgt_ff;
      endcase
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      l_in     = l_ff;
      r_in     = r_ff;
      c_in     = c_ff;
      cur_in   = cur_ff;
      drain_in = 1'b0;
      sat_in   = sat_ff;
      out0_in  = out0_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take && (req_mode == MODE_EVAL)) begin
               state_in = ST_BIAS;
               l_in     = '0;
               c_in     = '0;
               cur_in   = 1'b0;
               sat_in   = diff_hi || diff_lo;
            end
         end
         ST_BIAS: begin
            r_in     = '0;
            state_in = ST_ROWS;
         end
         ST_ROWS: begin
            if (last_row) begin
               state_in = ST_DRAIN;
            end else begin
               r_in = r_ff + IDX_W'(1);
            end
         end
         ST_DRAIN: begin
            drain_in = 1'b1;
            if (drain_ff) begin
               state_in = ST_STORE;
            end
         end
         ST_STORE: begin
            sat_in = sat_ff || mac_overflow;
            if (c_ff == '0) begin
               out0_in = a_wdata;
            end
            if (!last_col) begin
               c_in     = c_ff + IDX_W'(1);
               state_in = ST_BIAS;
            end else if (last_layer) begin
               state_in = ST_FINISH;
            end else begin
               l_in     = l_ff + LI_W'(1);
               c_in     = '0;
               cur_in   = !cur_ff;
               state_in = ST_BIAS;
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // response register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_drive_in  = rsp_drive_ff;
      rsp_error_in  = rsp_error_ff;
      rsp_status_in = rsp_status_ff;
      if (req_take && (req_mode != MODE_EVAL)) begin
         rsp_valid_in  = 1'b1;
         rsp_drive_in  = '0;
         rsp_error_in  = '0;
         rsp_status_in = write_ok ? STATUS_OK : STATUS_BAD_INDEX;
      end else if ((state_ff == ST_FINISH) && rsp_free) begin
         rsp_valid_in  = 1'b1;
         rsp_drive_in  = out0_ff;
         rsp_error_in  = err_ff;
         rsp_status_in = sat_ff ? STATUS_SAT : STATUS_OK;
      end else if (rsp_tready) begin
         rsp_valid_in  = 1'b0;
      end
   end

   // configuration writes
   always_comb begin
      num_layers_in = num_layers_ff;
      relu_mask_in  = relu_mask_ff;
      if (csr_we) begin
         case (reg_index_type'(csr_index))
            REG_NUM_LAYERS: num_layers_in = csr_wdata[NUM_LAYERS_W-1:0];
            REG_RELU_MASK:  relu_mask_in  = csr_wdata[RELU_MASK_W-1:0];
            default:        ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         num_layers_ff <= NUM_LAYERS_W'(1);
         relu_mask_ff  <= '0;
         for (int i = 0; i < MAX_LAYERS; i++) begin
            lw_ff[i] <= WIDTH_W'(1);
         end
         l_ff          <= '0;
         r_ff          <= '0;
         c_ff          <= '0;
         cur_ff        <= 1'b0;
         drain_ff      <= 1'b0;
         issue_ff      <= 1'b0;
         bias_v_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         num_layers_ff <= num_layers_in;
         relu_mask_ff  <= relu_mask_in;
         if (req_take && (req_mode == MODE_WIDTH) && write_ok) begin
            lw_ff[req_layer] <= req_width;
         end
         l_ff          <= l_in;
         r_ff          <= r_in;
         c_ff          <= c_in;
         cur_ff        <= cur_in;
         drain_ff      <= drain_in;
         issue_ff      <= state_ff == ST_ROWS;
         bias_v_ff     <= state_ff == ST_BIAS;
         rsp_valid_ff  <= rsp_valid_in;
      end
      // payload
      if (req_take && (req_mode == MODE_EVAL)) begin
         pos_ff <= req_pos;
         vel_ff <= req_vel;
         tgt_ff <= req_tgt;
         err_ff <= err_in;
      end
      x_ff          <= x_in;
      l0_ff         <= l_ff == '0;
      sat_ff        <= sat_in;
      out0_ff       <= out0_in;
      rsp_drive_ff  <= rsp_drive_in;
      rsp_error_ff  <= rsp_error_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-RSP_BITS){1'b0}}, rsp_status_ff, rsp_error_ff,
                        rsp_drive_ff};

endmodule

>>> design/mjec_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mjec_checker - port level checks of the joint effort controller
// watches the request and response ports over time
// ----------------------------------------------------------------------------
module mjec_checker import mjec_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic [REQ_USER_W-1:0] req_tuser,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic [STATUS_W-1:0] status;
   logic [DATA_W-1:0]   drive;
   logic [DATA_W-1:0]   error;

   assign status = rsp_tdata[RSP_STATUS_LSB +: STATUS_W];
   assign drive  = rsp_tdata[RSP_DRIVE_LSB +: DATA_W];
   assign error  = rsp_tdata[RSP_ERROR_LSB +: DATA_W];

   // no response right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   // a table write answers in the next cycle
   a_write_answer: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser != MODE_EVAL) |=> rsp_tvalid)
      else $error("write request not answered in the next cycle");

   // a rejected write carries zero drive and error
   a_bad_index_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (status == STATUS_BAD_INDEX) |-> (drive == '0) && (error == '0))
      else $error("rejected write with nonzero payload");

   // only defined status codes leave the block
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (status == STATUS_OK) || (status == STATUS_BAD_INDEX)
                     || (status == STATUS_SAT))
      else $error("undefined status code");

endmodule

bind mlp_joint_effort_controller mjec_checker u_checker (.*);
